### rtl/core/akc_pkg.sv
package akc_pkg;

    // Scan phase of the current byte sequence
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_PREFIX = 3'd1,
        PH_SCAN   = 3'd2,
        PH_HDR0   = 3'd3,
        PH_HDR1   = 3'd4
    } phase_t;

    // Sequence modes, taken from the first byte
    localparam logic MODE_PARAM = 1'b0;
    localparam logic MODE_SLICE = 1'b1;

    // Verdict kinds
    localparam logic KIND_CODEC    = 1'b0;
    localparam logic KIND_KEYFRAME = 1'b1;

    // Start code and NAL header fields
    localparam logic [7:0] BYTE_ZERO       = 8'h00;
    localparam logic [7:0] BYTE_ONE        = 8'h01;
    localparam logic [7:0] FORBIDDEN_MASK  = 8'h80;
    localparam logic [7:0] LAYER_LSB_MASK  = 8'h01;
    localparam logic [7:0] AVC_TYPE_MASK   = 8'h1f;
    localparam logic [5:0] HEVC_NUT_MASK   = 6'h3f;
    localparam logic [5:0] HEVC_VPS        = 6'd32;
    localparam logic [5:0] HEVC_SPS        = 6'd33;
    localparam logic [5:0] HEVC_PPS        = 6'd34;
    localparam logic [5:0] HEVC_IRAP_LO    = 6'd16;
    localparam logic [5:0] HEVC_IRAP_HI    = 6'd21;
    localparam logic [4:0] AVC_IDR         = 5'd5;
    localparam logic [4:0] AVC_SPS         = 5'd7;
    localparam logic [4:0] AVC_PPS         = 5'd8;

    // Zero run saturates at two
    localparam logic [1:0] ZERO_RUN_MAX = 2'd2;

    typedef struct packed {
        logic verdict;
        logic verdict_kind;
        logic codec_in_force;
    } result_t;

endpackage

### rtl/core/akc_in_if.sv
interface akc_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output mode, output data_byte, output last, input ready);
    modport sink (input valid, input mode, input data_byte, input last, output ready);
endinterface

### rtl/core/akc_out_if.sv
interface akc_out_if;
    logic valid;
    logic ready;
    logic verdict;
    logic verdict_kind;
    logic codec_in_force;

    modport source (output valid, output verdict, output verdict_kind, output codec_in_force,
                    input ready);
    modport sink (input valid, input verdict, input verdict_kind, input codec_in_force,
                  output ready);
endinterface

### rtl/core/annexb_codec_and_keyframe_classifier.sv
// Channel   | Dir | Beat payload                          | Beats
// ----------+-----+---------------------------------------+---------------------------
// bytes     | in  | mode, data_byte, last                 | one per byte of a sequence
// verdicts  | out | verdict, verdict_kind, codec_in_force | at most one per sequence
//
// One byte is taken every cycle while the skid entry is empty; the scan state is registered on
// each accepted byte, and a verdict goes to the output register, or to the skid if that is held.
// A two-entry output stage (register plus skid) lets bytes keep flowing while a
// verdict waits; bytes stall only when both entries are full.
// Reset clears the scan state and the codec flag (H.264) and empties the output.
module annexb_codec_and_keyframe_classifier #(
    parameter int HEADER_CAPACITY = 256,
    parameter int PREFIX_BYTES    = 2
) (
    input  logic      clk,
    input  logic      rst_n,
    akc_in_if.sink    bytes,
    akc_out_if.source verdicts
);

    localparam int CW = $clog2(HEADER_CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C    = CW'(HEADER_CAPACITY);
    localparam logic [CW-1:0] PREFIX_C = CW'(PREFIX_BYTES);

    // Scan state
    akc_pkg::phase_t phase_reg, phase_next;
    logic            mode_reg, mode_next;
    logic [1:0]      zero_run_reg, zero_run_next;
    logic [7:0]      hdr_byte_reg, hdr_byte_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            decided_reg, decided_next;
    logic            codec_reg, codec_next;

    // Output stage
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    akc_pkg::result_t out_reg, out_next;
    akc_pkg::result_t skid_reg, skid_next;

    // Per-byte decode
    logic             in_fire;
    logic             out_fire;
    logic             settle;
    logic             settle_val;
    logic             eff_mode;
    akc_pkg::result_t result;

    assign in_fire  = bytes.valid && bytes.ready;
    assign out_fire = verdicts.valid && verdicts.ready;

    // Decode one byte into the next scan state
    always_comb
    begin
        akc_pkg::phase_t ph;
        logic [1:0]      zr;
        logic [7:0]      hb;
        logic [CW-1:0]   cnt;
        logic [CW-1:0]   cnt_inc;
        logic            dec;
        logic [7:0]      b;
        logic [5:0]      t_hb;
        logic [5:0]      t_b;
        logic            hevc_hdr;
        logic            avc_hdr;
        akc_pkg::phase_t ph_n;

        b = bytes.data_byte;
        // Fresh sequence: take the mode and start from a clean state
        if (phase_reg == akc_pkg::PH_IDLE)
        begin
            eff_mode = bytes.mode;
            ph  = (bytes.mode == akc_pkg::MODE_SLICE) ? akc_pkg::PH_PREFIX : akc_pkg::PH_SCAN;
            zr  = '0;
            hb  = '0;
            cnt = '0;
            dec = 1'b0;
        end
        else
        begin
            eff_mode = mode_reg;
            ph  = phase_reg;
            zr  = zero_run_reg;
            hb  = hdr_byte_reg;
            cnt = count_reg;
            dec = decided_reg;
        end

        cnt_inc    = (cnt == CAP_C) ? cnt : cnt + 1'b1;
        t_hb       = 6'((hb >> 1) & {2'b00, akc_pkg::HEVC_NUT_MASK});
        t_b        = 6'((b >> 1) & {2'b00, akc_pkg::HEVC_NUT_MASK});
        hevc_hdr   = ((hb & akc_pkg::FORBIDDEN_MASK) == '0)
                     && ((hb & akc_pkg::LAYER_LSB_MASK) == '0)
                     && (b == akc_pkg::BYTE_ONE)
                     && (t_hb inside {akc_pkg::HEVC_VPS, akc_pkg::HEVC_SPS, akc_pkg::HEVC_PPS});
        avc_hdr    = ((hb & akc_pkg::FORBIDDEN_MASK) == '0)
                     && (5'(hb & akc_pkg::AVC_TYPE_MASK) inside {akc_pkg::AVC_SPS,
                                                                 akc_pkg::AVC_PPS});
        ph_n       = ph;
        zero_run_next = zr;
        hdr_byte_next = hb;
        count_next    = cnt;
        settle        = 1'b0;
        settle_val    = 1'b0;

        if (!dec)
        begin
            count_next = cnt_inc;
            if (eff_mode == akc_pkg::MODE_PARAM)
            begin
                case (ph)
                    akc_pkg::PH_SCAN:
                    begin
                        if (zr == akc_pkg::ZERO_RUN_MAX && b == akc_pkg::BYTE_ONE)
                        begin
                            ph_n          = akc_pkg::PH_HDR0;
                            zero_run_next = '0;
                        end
                        else if (b == akc_pkg::BYTE_ZERO)
                        begin
                            zero_run_next = (zr < akc_pkg::ZERO_RUN_MAX) ? zr + 1'b1 : zr;
                        end
                        else
                        begin
                            zero_run_next = '0;
                        end
                    end
                    akc_pkg::PH_HDR0:
                    begin
                        hdr_byte_next = b;
                        ph_n          = akc_pkg::PH_HDR1;
                    end
                    default:
                    begin
                        if (hevc_hdr)
                        begin
                            settle     = 1'b1;
                            settle_val = 1'b1;
                        end
                        else if (avc_hdr)
                        begin
                            settle     = 1'b1;
                            settle_val = 1'b0;
                        end
                        else
                        begin
                            ph_n          = akc_pkg::PH_SCAN;
                            zero_run_next = (b == akc_pkg::BYTE_ZERO) ? 2'd1 : 2'd0;
                        end
                    end
                endcase
                // Give up on H.264 once the header window is full
                if (!settle && cnt_inc >= CAP_C)
                begin
                    settle     = 1'b1;
                    settle_val = 1'b0;
                end
            end
            else
            begin
                if (ph == akc_pkg::PH_PREFIX && cnt < PREFIX_C)
                begin
                    ph_n = akc_pkg::PH_PREFIX;
                end
                else if (ph == akc_pkg::PH_PREFIX || ph == akc_pkg::PH_SCAN)
                begin
                    if (b == akc_pkg::BYTE_ONE)
                    begin
                        ph_n = akc_pkg::PH_HDR0;
                    end
                    else if (b != akc_pkg::BYTE_ZERO)
                    begin
                        ph_n       = akc_pkg::PH_SCAN;
                        settle     = 1'b1;
                        settle_val = 1'b0;
                    end
                    else
                    begin
                        ph_n = akc_pkg::PH_SCAN;
                    end
                end
                else
                begin
                    // Header byte after the start code
                    settle = 1'b1;
                    if (codec_reg)
                        settle_val = (t_b >= akc_pkg::HEVC_IRAP_LO)
                                     && (t_b <= akc_pkg::HEVC_IRAP_HI);
                    else
                        settle_val = (5'(b & akc_pkg::AVC_TYPE_MASK) == akc_pkg::AVC_IDR);
                end
            end
            // Sequence ended undecided
            if (!settle && bytes.last)
            begin
                settle     = 1'b1;
                settle_val = 1'b0;
            end
        end

        decided_next = dec || settle;
        codec_next   = (settle && eff_mode == akc_pkg::MODE_PARAM) ? settle_val : codec_reg;
        mode_next    = eff_mode;
        phase_next   = ph_n;

        // Close the sequence on its last byte
        if (bytes.last)
        begin
            phase_next    = akc_pkg::PH_IDLE;
            decided_next  = 1'b0;
            zero_run_next = '0;
            count_next    = '0;
        end
    end

    // Form the result beat
    always_comb
    begin
        result.verdict        = settle_val;
        result.verdict_kind   = eff_mode ? akc_pkg::KIND_KEYFRAME : akc_pkg::KIND_CODEC;
        result.codec_in_force = codec_next;
    end

    // Advance the output register and skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (in_fire && settle)
            begin
                out_next       = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_fire && settle)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= akc_pkg::PH_IDLE;
            mode_reg       <= akc_pkg::MODE_PARAM;
            zero_run_reg   <= '0;
            hdr_byte_reg   <= '0;
            count_reg      <= '0;
            decided_reg    <= 1'b0;
            codec_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg    <= phase_next;
                mode_reg     <= mode_next;
                zero_run_reg <= zero_run_next;
                hdr_byte_reg <= hdr_byte_next;
                count_reg    <= count_next;
                decided_reg  <= decided_next;
                codec_reg    <= codec_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign bytes.ready             = !skid_valid_reg;
    assign verdicts.valid          = out_valid_reg;
    assign verdicts.verdict        = out_reg.verdict;
    assign verdicts.verdict_kind   = out_reg.verdict_kind;
    assign verdicts.codec_in_force = out_reg.codec_in_force;

endmodule

### rtl/core/akc_checker.sv
module akc_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic verdict,
    input logic verdict_kind,
    input logic codec_in_force
);

    // Hold a stalled verdict beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(verdict)
            && $stable(verdict_kind) && $stable(codec_in_force))
        else $error("verdict beat changed while stalled");

    // A codec verdict is the codec flag it leaves behind
    a_codec_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict_kind == akc_pkg::KIND_CODEC |-> codec_in_force == verdict)
        else $error("codec verdict disagrees with stored flag");

    // A fresh verdict follows an accepted byte
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("verdict without an accepted byte");

    // Input stalls only while a verdict is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty output");

endmodule

bind annexb_codec_and_keyframe_classifier akc_checker u_akc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (bytes.valid),
    .in_ready       (bytes.ready),
    .out_valid      (verdicts.valid),
    .out_ready      (verdicts.ready),
    .verdict        (verdicts.verdict),
    .verdict_kind   (verdicts.verdict_kind),
    .codec_in_force (verdicts.codec_in_force)
);
